>>> rtl/sd_request_completion_tracker_macros.svh
// assertion macros for the request completion tracker
`ifndef SD_REQUEST_COMPLETION_TRACKER_MACROS_SVH
`define SD_REQUEST_COMPLETION_TRACKER_MACROS_SVH

`ifndef NO_ASSERTIONS
// check a property on the rising clock edge, skipped while reset is low
`define SDRCT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sdrct assertion failed");
// same check with a message of its own
`define SDRCT_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
`else
`define SDRCT_ASSERT(lbl, clk, rstn, prop)
`define SDRCT_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

>>> rtl/sdrct_pkg.sv
package sdrct_pkg;

    // transaction kinds on the input channel
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_STATUS = 2'd1;
    localparam logic [1:0] ACT_DMA    = 2'd2;
    localparam logic [1:0] ACT_RETIRE = 2'd3;

    // awaited phase codes
    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_SENT = 3'd1;
    localparam logic [2:0] PH_RSP  = 3'd2;
    localparam logic [2:0] PH_XFER = 3'd3;
    localparam logic [2:0] PH_BOTH = 3'd4;

    // command error codes
    localparam logic [1:0] CERR_NONE    = 2'd0;
    localparam logic [1:0] CERR_TIMEOUT = 2'd1;
    localparam logic [1:0] CERR_CRC     = 2'd2;

    // data error codes
    localparam logic [2:0] DERR_NONE    = 3'd0;
    localparam logic [2:0] DERR_FIFO    = 3'd1;
    localparam logic [2:0] DERR_CRC     = 3'd2;
    localparam logic [2:0] DERR_TIMEOUT = 3'd3;
    localparam logic [2:0] DERR_FAILED  = 3'd4;

    // command status bits
    localparam int CS_TIMEOUT = 0;
    localparam int CS_SENT    = 1;
    localparam int CS_CRC     = 2;
    localparam int CS_RSP_END = 3;

    // data status bits
    localparam int DS_FIFO    = 0;
    localparam int DS_RX_CRC  = 1;
    localparam int DS_CRC     = 2;
    localparam int DS_TIMEOUT = 3;
    localparam int DS_FINISH  = 4;
    localparam int DS_RX_LAST = 5;

    // command clear bits
    localparam int CC_SENT    = 0;
    localparam int CC_CRC     = 1;
    localparam int CC_RSP_END = 2;

    typedef struct packed {
        logic [1:0] action;
        logic       has_response;
        logic       long_response;
        logic       check_crc;
        logic       has_data;
        logic       is_read;
        logic [3:0] cmd_status;
        logic [5:0] data_status;
        logic       dma_result_ok;
        logic       words_left_nonzero;
    } item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       request_active;
        logic       data_present;
        logic       long_rsp;
        logic       crc_checked;
        logic       read_dir;
        logic [1:0] cmd_err;
        logic [2:0] data_err;
    } track_state_t;

    typedef struct packed {
        logic       req_closed;
        logic [1:0] cmd_error;
        logic [2:0] data_error;
        logic [2:0] cmd_clear;
        logic       data_clear;
        logic       mask_cleared;
    } result_t;

endpackage

>>> rtl/sdrct_step.sv
module sdrct_step (
    input  sdrct_pkg::item_t        item,
    input  sdrct_pkg::track_state_t st,
    output sdrct_pkg::track_state_t st_next,
    output sdrct_pkg::result_t      res
);

    logic       close;
    logic [2:0] cclr;
    logic       dclr;
    logic       bad_dma;

    // start, status, dma and retire events; status checks in fixed priority, later checks see earlier phase moves
    always_comb begin
        st_next = st;
        res     = '0;
        close   = 1'b0;
        cclr    = '0;
        dclr    = 1'b0;
        bad_dma = !item.dma_result_ok || (st.read_dir && item.words_left_nonzero);

        unique case (item.action)
            sdrct_pkg::ACT_START: begin
                st_next.phase = item.has_data ? sdrct_pkg::PH_BOTH :
                                item.has_response ? sdrct_pkg::PH_RSP :
                                sdrct_pkg::PH_SENT;
                st_next.request_active = 1'b1;
                st_next.data_present   = item.has_data;
                st_next.long_rsp       = item.long_response;
                st_next.crc_checked    = item.check_crc;
                st_next.read_dir       = item.is_read;
                st_next.cmd_err        = sdrct_pkg::CERR_NONE;
                st_next.data_err       = sdrct_pkg::DERR_NONE;
            end
            sdrct_pkg::ACT_STATUS: begin
                if (st.phase == sdrct_pkg::PH_NONE || !st.request_active) begin
                    res.mask_cleared = 1'b1;
                end else begin
                    // command side
                    if (item.cmd_status[sdrct_pkg::CS_TIMEOUT]) begin
                        st_next.cmd_err = sdrct_pkg::CERR_TIMEOUT;
                        close = 1'b1;
                    end
                    if (!close && item.cmd_status[sdrct_pkg::CS_SENT]) begin
                        if (st_next.phase == sdrct_pkg::PH_SENT) begin
                            st_next.cmd_err = sdrct_pkg::CERR_NONE;
                            close = 1'b1;
                        end else begin
                            cclr[sdrct_pkg::CC_SENT] = 1'b1;
                        end
                    end
                    if (!close && item.cmd_status[sdrct_pkg::CS_CRC]) begin
                        // long responses never fail on crc
                        if (!st.long_rsp && st.crc_checked) begin
                            st_next.cmd_err = sdrct_pkg::CERR_CRC;
                            close = 1'b1;
                        end else begin
                            cclr[sdrct_pkg::CC_CRC] = 1'b1;
                        end
                    end
                    if (!close && item.cmd_status[sdrct_pkg::CS_RSP_END]) begin
                        if (st_next.phase == sdrct_pkg::PH_RSP) begin
                            st_next.cmd_err = sdrct_pkg::CERR_NONE;
                            close = 1'b1;
                        end else begin
                            if (st_next.phase == sdrct_pkg::PH_BOTH) begin
                                st_next.cmd_err = sdrct_pkg::CERR_NONE;
                                st_next.phase   = sdrct_pkg::PH_XFER;
                            end
                            cclr[sdrct_pkg::CC_RSP_END] = 1'b1;
                        end
                    end
                    // data side, only with a transfer
                    if (!close && st.data_present) begin
                        if (item.data_status[sdrct_pkg::DS_FIFO]) begin
                            st_next.cmd_err  = sdrct_pkg::CERR_NONE;
                            st_next.data_err = sdrct_pkg::DERR_FIFO;
                            close = 1'b1;
                        end else if (item.data_status[sdrct_pkg::DS_RX_CRC]) begin
                            st_next.cmd_err  = sdrct_pkg::CERR_NONE;
                            st_next.data_err = sdrct_pkg::DERR_CRC;
                            close = 1'b1;
                        end else if (item.data_status[sdrct_pkg::DS_CRC]) begin
                            // data crc flag closes with no error
                            st_next.cmd_err  = sdrct_pkg::CERR_NONE;
                            st_next.data_err = sdrct_pkg::DERR_NONE;
                            close = 1'b1;
                        end else if (item.data_status[sdrct_pkg::DS_TIMEOUT]) begin
                            st_next.cmd_err  = sdrct_pkg::CERR_NONE;
                            st_next.data_err = sdrct_pkg::DERR_TIMEOUT;
                            close = 1'b1;
                        end else begin
                            if (item.data_status[sdrct_pkg::DS_FINISH]) begin
                                if (st_next.phase == sdrct_pkg::PH_XFER) begin
                                    st_next.cmd_err  = sdrct_pkg::CERR_NONE;
                                    st_next.data_err = sdrct_pkg::DERR_NONE;
                                    close = 1'b1;
                                end else begin
                                    if (st_next.phase == sdrct_pkg::PH_BOTH) begin
                                        st_next.data_err = sdrct_pkg::DERR_NONE;
                                        st_next.phase    = sdrct_pkg::PH_RSP;
                                    end
                                    dclr = 1'b1;
                                end
                            end
                            if (!close && item.data_status[sdrct_pkg::DS_RX_LAST]) begin
                                st_next.cmd_err  = sdrct_pkg::CERR_NONE;
                                st_next.data_err = sdrct_pkg::DERR_NONE;
                                close = 1'b1;
                            end
                        end
                    end
                    // closing reports the collected clear bits
                    if (close) begin
                        st_next.phase    = sdrct_pkg::PH_NONE;
                        res.req_closed   = 1'b1;
                        res.mask_cleared = 1'b1;
                        res.cmd_clear    = cclr;
                        res.data_clear   = dclr;
                    end
                end
            end
            sdrct_pkg::ACT_DMA: begin
                if (st.request_active && st.data_present && bad_dma) begin
                    st_next.data_err = sdrct_pkg::DERR_FAILED;
                    st_next.phase    = sdrct_pkg::PH_NONE;
                    res.req_closed   = 1'b1;
                    res.mask_cleared = 1'b1;
                end
            end
            sdrct_pkg::ACT_RETIRE: begin
                st_next.request_active = 1'b0;
                st_next.phase          = sdrct_pkg::PH_NONE;
                res.mask_cleared       = 1'b1;
            end
            default: begin
                st_next = st;
            end
        endcase

        res.cmd_error  = st_next.cmd_err;
        res.data_error = st_next.data_err;
    end

endmodule

>>> rtl/sd_request_completion_tracker.sv
// request completion tracker for an sd/mmc host
// input channel (s_*): one transaction per event: start request, status
//   interrupt, dma done, or retire request, with the fields each kind uses
// result channel (m_*): exactly one result transaction per input transaction,
//   in order: request closed flag, command and data error codes, status clear
//   bits and the mask clear flag
// path: an accepted transaction passes the input register, then the result
//   register, and m_valid rises once it reaches the result register
// throughput: one transaction per cycle while the receiver keeps m_ready high;
//   the tracking state is updated as an item moves between the two registers
// reset (aresetn low, synchronous): no request active, nothing awaited,
//   error codes zero, both registers empty
// receiver stall: the result register holds its transaction, the input
//   register keeps one more, and s_ready then drops until m_ready returns
`include "sd_request_completion_tracker_macros.svh"

module sd_request_completion_tracker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic       s_has_response,
    input  logic       s_long_response,
    input  logic       s_check_crc,
    input  logic       s_has_data,
    input  logic       s_is_read,
    input  logic [3:0] s_cmd_status,
    input  logic [5:0] s_data_status,
    input  logic       s_dma_result_ok,
    input  logic       s_words_left_nonzero,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_req_closed,
    output logic [1:0] m_cmd_error,
    output logic [2:0] m_data_error,
    output logic [2:0] m_cmd_clear,
    output logic       m_data_clear,
    output logic       m_mask_cleared
);

    logic                    in_valid_reg;
    sdrct_pkg::item_t        item_reg;
    sdrct_pkg::item_t        item_next;
    sdrct_pkg::track_state_t st_reg;
    sdrct_pkg::track_state_t st_next;
    logic                    out_valid_reg;
    sdrct_pkg::result_t      res_reg;
    sdrct_pkg::result_t      res_next;
    logic                    advance;
    logic                    s_fire;

    // pipeline handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign item_next = '{
        action:             s_action,
        has_response:       s_has_response,
        long_response:      s_long_response,
        check_crc:          s_check_crc,
        has_data:           s_has_data,
        is_read:            s_is_read,
        cmd_status:         s_cmd_status,
        data_status:        s_data_status,
        dma_result_ok:      s_dma_result_ok,
        words_left_nonzero: s_words_left_nonzero
    };

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_fire) begin
            item_reg <= item_next;
        end
    end

    // event evaluation
    sdrct_step u_step (
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_req_closed   = res_reg.req_closed;
    assign m_cmd_error    = res_reg.cmd_error;
    assign m_data_error   = res_reg.data_error;
    assign m_cmd_clear    = res_reg.cmd_clear;
    assign m_data_clear   = res_reg.data_clear;
    assign m_mask_cleared = res_reg.mask_cleared;

    // a phase is only awaited while a request is open
    `SDRCT_ASSERT_MSG(a_phase_needs_active, aclk, aresetn, (st_reg.phase != sdrct_pkg::PH_NONE) |-> st_reg.request_active, "phase set with no active request")
    // closing a request always clears the interrupt mask
    `SDRCT_ASSERT(a_done_clears_mask, aclk, aresetn, (m_valid && m_req_closed) |-> m_mask_cleared)
    // clear bits go out only with a closing result
    `SDRCT_ASSERT(a_clear_needs_done, aclk, aresetn, (m_valid && (m_cmd_clear != 3'd0 || m_data_clear)) |-> m_req_closed)
    // a start opens a clean request
    `SDRCT_ASSERT_MSG(a_start_opens, aclk, aresetn, (advance && item_reg.action == sdrct_pkg::ACT_START) |=> (st_reg.request_active && st_reg.cmd_err == sdrct_pkg::CERR_NONE && st_reg.data_err == sdrct_pkg::DERR_NONE), "start did not open a clean request")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // clock, reset and block ports
    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_action = sdrct_pkg::ACT_RETIRE;
    logic       s_has_response = 1'b0;
    logic       s_long_response = 1'b0;
    logic       s_check_crc = 1'b0;
    logic       s_has_data = 1'b0;
    logic       s_is_read = 1'b0;
    logic [3:0] s_cmd_status = '0;
    logic [5:0] s_data_status = '0;
    logic       s_dma_result_ok = 1'b0;
    logic       s_words_left_nonzero = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_req_closed;
    logic [1:0] m_cmd_error;
    logic [2:0] m_data_error;
    logic [2:0] m_cmd_clear;
    logic       m_data_clear;
    logic       m_mask_cleared;

    sd_request_completion_tracker dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_has_response       (s_has_response),
        .s_long_response      (s_long_response),
        .s_check_crc          (s_check_crc),
        .s_has_data           (s_has_data),
        .s_is_read            (s_is_read),
        .s_cmd_status         (s_cmd_status),
        .s_data_status        (s_data_status),
        .s_dma_result_ok      (s_dma_result_ok),
        .s_words_left_nonzero (s_words_left_nonzero),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_req_closed         (m_req_closed),
        .m_cmd_error          (m_cmd_error),
        .m_data_error         (m_data_error),
        .m_cmd_clear          (m_cmd_clear),
        .m_data_clear         (m_data_clear),
        .m_mask_cleared       (m_mask_cleared)
    );

    // events waiting to go out, and completions the tracker owes us
    sdrct_pkg::item_t   events_to_send[$];
    sdrct_pkg::result_t completions_due[$];
    sdrct_pkg::item_t   on_bus = '0;

    // shadow copy of the request tracking state
    logic [2:0] trk_phase = sdrct_pkg::PH_NONE;
    logic       trk_active = 1'b0;
    logic       trk_data = 1'b0;
    logic       trk_long = 1'b0;
    logic       trk_crc = 1'b0;
    logic       trk_read = 1'b0;
    logic [1:0] trk_cerr = sdrct_pkg::CERR_NONE;
    logic [2:0] trk_derr = sdrct_pkg::DERR_NONE;

    // bookkeeping
    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_closed = 0;
    int n_cmd_errs = 0;
    int n_data_errs = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int rx_tick = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // reset held low at start, then released on a clock edge
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // run limit
    initial begin
        #2ms;
        $display("timeout with %0d completions still due", completions_due.size());
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
        if (n_errors < 30)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want_v, got_v);
        n_errors++;
    endtask

    // work out what the tracker reports for one event, advancing the shadow state
    function automatic sdrct_pkg::result_t next_completion(sdrct_pkg::item_t ev);
        sdrct_pkg::result_t r;
        logic       closed;
        logic       bad;
        logic [2:0] cc;
        logic       dc;
        logic [3:0] cs;
        logic [5:0] ds;
        r = '0;
        closed = 1'b0;
        cc = '0;
        dc = 1'b0;
        cs = ev.cmd_status;
        ds = ev.data_status;
        case (ev.action)
            sdrct_pkg::ACT_START: begin
                trk_phase = ev.has_data ? sdrct_pkg::PH_BOTH :
                            (ev.has_response ? sdrct_pkg::PH_RSP : sdrct_pkg::PH_SENT);
                trk_active = 1'b1;
                trk_data = ev.has_data;
                trk_long = ev.long_response;
                trk_crc = ev.check_crc;
                trk_read = ev.is_read;
                trk_cerr = sdrct_pkg::CERR_NONE;
                trk_derr = sdrct_pkg::DERR_NONE;
            end
            sdrct_pkg::ACT_STATUS: begin
                if (trk_phase == sdrct_pkg::PH_NONE || !trk_active) begin
                    r.mask_cleared = 1'b1;
                end else begin
                    // command status, highest priority first
                    if (cs[sdrct_pkg::CS_TIMEOUT]) begin
                        trk_cerr = sdrct_pkg::CERR_TIMEOUT;
                        closed = 1'b1;
                    end
                    if (!closed && cs[sdrct_pkg::CS_SENT]) begin
                        if (trk_phase == sdrct_pkg::PH_SENT) begin
                            trk_cerr = sdrct_pkg::CERR_NONE;
                            closed = 1'b1;
                        end else cc[sdrct_pkg::CC_SENT] = 1'b1;
                    end
                    if (!closed && cs[sdrct_pkg::CS_CRC]) begin
                        if (!trk_long && trk_crc) begin
                            trk_cerr = sdrct_pkg::CERR_CRC;
                            closed = 1'b1;
                        end else cc[sdrct_pkg::CC_CRC] = 1'b1;
                    end
                    if (!closed && cs[sdrct_pkg::CS_RSP_END]) begin
                        if (trk_phase == sdrct_pkg::PH_RSP) begin
                            trk_cerr = sdrct_pkg::CERR_NONE;
                            closed = 1'b1;
                        end else begin
                            if (trk_phase == sdrct_pkg::PH_BOTH) begin
                                trk_cerr = sdrct_pkg::CERR_NONE;
                                trk_phase = sdrct_pkg::PH_XFER;
                            end
                            cc[sdrct_pkg::CC_RSP_END] = 1'b1;
                        end
                    end
                    // data status only counts for a data request
                    if (!closed && trk_data) begin
                        if (ds[sdrct_pkg::DS_FIFO]) begin
                            trk_cerr = sdrct_pkg::CERR_NONE;
                            trk_derr = sdrct_pkg::DERR_FIFO;
                            closed = 1'b1;
                        end else if (ds[sdrct_pkg::DS_RX_CRC]) begin
                            trk_cerr = sdrct_pkg::CERR_NONE;
                            trk_derr = sdrct_pkg::DERR_CRC;
                            closed = 1'b1;
                        end else if (ds[sdrct_pkg::DS_CRC]) begin
                            // data crc flag closes the request as a success
                            trk_cerr = sdrct_pkg::CERR_NONE;
                            trk_derr = sdrct_pkg::DERR_NONE;
                            closed = 1'b1;
                        end else if (ds[sdrct_pkg::DS_TIMEOUT]) begin
                            trk_cerr = sdrct_pkg::CERR_NONE;
                            trk_derr = sdrct_pkg::DERR_TIMEOUT;
                            closed = 1'b1;
                        end else begin
                            if (ds[sdrct_pkg::DS_FINISH]) begin
                                if (trk_phase == sdrct_pkg::PH_XFER) begin
                                    trk_cerr = sdrct_pkg::CERR_NONE;
                                    trk_derr = sdrct_pkg::DERR_NONE;
                                    closed = 1'b1;
                                end else begin
                                    if (trk_phase == sdrct_pkg::PH_BOTH) begin
                                        trk_derr = sdrct_pkg::DERR_NONE;
                                        trk_phase = sdrct_pkg::PH_RSP;
                                    end
                                    dc = 1'b1;
                                end
                            end
                            if (!closed && ds[sdrct_pkg::DS_RX_LAST]) begin
                                trk_cerr = sdrct_pkg::CERR_NONE;
                                trk_derr = sdrct_pkg::DERR_NONE;
                                closed = 1'b1;
                            end
                        end
                    end
                    if (closed) begin
                        trk_phase = sdrct_pkg::PH_NONE;
                        r.req_closed = 1'b1;
                        r.mask_cleared = 1'b1;
                        r.cmd_clear = cc;
                        r.data_clear = dc;
                    end
                end
            end
            sdrct_pkg::ACT_DMA: begin
                if (trk_active && trk_data) begin
                    bad = !ev.dma_result_ok || (trk_read && ev.words_left_nonzero);
                    if (bad) begin
                        trk_derr = sdrct_pkg::DERR_FAILED;
                        trk_phase = sdrct_pkg::PH_NONE;
                        r.req_closed = 1'b1;
                        r.mask_cleared = 1'b1;
                    end
                end
            end
            default: begin
                trk_active = 1'b0;
                trk_phase = sdrct_pkg::PH_NONE;
                r.mask_cleared = 1'b1;
            end
        endcase
        r.cmd_error = trk_cerr;
        r.data_error = trk_derr;
        return r;
    endfunction

    // event builders: fields the action ignores carry random noise
    function automatic sdrct_pkg::item_t noise_ev();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(sdrct_pkg::item_t)-1:0];
    endfunction

    function automatic sdrct_pkg::item_t start_ev(logic rsp, logic lng, logic crc, logic dat,
                                                  logic rd);
        sdrct_pkg::item_t ev;
        ev = noise_ev();
        ev.action = sdrct_pkg::ACT_START;
        ev.has_response = rsp;
        ev.long_response = lng;
        ev.check_crc = crc;
        ev.has_data = dat;
        ev.is_read = rd;
        return ev;
    endfunction

    function automatic sdrct_pkg::item_t status_ev(logic [3:0] cs, logic [5:0] ds);
        sdrct_pkg::item_t ev;
        ev = noise_ev();
        ev.action = sdrct_pkg::ACT_STATUS;
        ev.cmd_status = cs;
        ev.data_status = ds;
        return ev;
    endfunction

    function automatic sdrct_pkg::item_t dma_ev(logic ok, logic left);
        sdrct_pkg::item_t ev;
        ev = noise_ev();
        ev.action = sdrct_pkg::ACT_DMA;
        ev.dma_result_ok = ok;
        ev.words_left_nonzero = left;
        return ev;
    endfunction

    function automatic sdrct_pkg::item_t retire_ev();
        sdrct_pkg::item_t ev;
        ev = noise_ev();
        ev.action = sdrct_pkg::ACT_RETIRE;
        return ev;
    endfunction

    // each bit set with probability one in four, so several flags can race
    function automatic logic [5:0] sparse_bits();
        logic [5:0] v;
        for (int i = 0; i < 6; i++)
            v[i] = ($urandom_range(0, 3) == 0);
        return v;
    endfunction

    // one random bit
    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // driver: bursts of transactions separated by random gaps
    always @(posedge aclk) begin
        sdrct_pkg::item_t nxt;
        logic  give;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            give = s_valid;
            if (s_valid && s_ready) begin
                completions_due.push_back(next_completion(on_bus));
                n_accepted <= n_accepted + 1;
                give = 1'b0;
            end
            if (!give) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (events_to_send.size() != 0) begin
                    nxt = events_to_send.pop_front();
                    on_bus <= nxt;
                    s_action <= nxt.action;
                    s_has_response <= nxt.has_response;
                    s_long_response <= nxt.long_response;
                    s_check_crc <= nxt.check_crc;
                    s_has_data <= nxt.has_data;
                    s_is_read <= nxt.is_read;
                    s_cmd_status <= nxt.cmd_status;
                    s_data_status <= nxt.data_status;
                    s_dma_result_ok <= nxt.dma_result_ok;
                    s_words_left_nonzero <= nxt.words_left_nonzero;
                    give = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            s_valid <= give;
        end
    end

    // receiver: changing stall patterns plus two long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (holds_done < 2 && n_accepted >= (holds_done + 1) * 500) begin
            hold_left <= 60;
            holds_done <= holds_done + 1;
            m_ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= coin();
                2:       m_ready <= (rx_tick % 4 == 0);
                default: m_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // monitor: compare each result transaction with the oldest completion due
    always @(posedge aclk) begin
        sdrct_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            n_results++;
            if (completions_due.size() == 0) begin
                report_mismatch("result with no completion due", 0, 1);
            end else begin
                want = completions_due.pop_front();
                if (m_req_closed !== want.req_closed)
                    report_mismatch("req_closed", 32'(want.req_closed), 32'(m_req_closed));
                if (m_cmd_error !== want.cmd_error)
                    report_mismatch("cmd_error", 32'(want.cmd_error), 32'(m_cmd_error));
                if (m_data_error !== want.data_error)
                    report_mismatch("data_error", 32'(want.data_error), 32'(m_data_error));
                if (m_cmd_clear !== want.cmd_clear)
                    report_mismatch("cmd_clear", 32'(want.cmd_clear), 32'(m_cmd_clear));
                if (m_data_clear !== want.data_clear)
                    report_mismatch("data_clear", 32'(want.data_clear), 32'(m_data_clear));
                if (m_mask_cleared !== want.mask_cleared)
                    report_mismatch("mask_cleared", 32'(want.mask_cleared),
                                    32'(m_mask_cleared));
                if (want.req_closed) n_closed++;
                if (want.req_closed && want.cmd_error != sdrct_pkg::CERR_NONE) n_cmd_errs++;
                if (want.req_closed && want.data_error != sdrct_pkg::DERR_NONE) n_data_errs++;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int n_status;
        // status, dma and retire with no request open
        events_to_send.push_back(status_ev(4'hf, 6'h3f));
        events_to_send.push_back(dma_ev(1'b0, 1'b1));
        events_to_send.push_back(retire_ev());
        // command only, closed by sent
        events_to_send.push_back(start_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        events_to_send.push_back(status_ev(4'b0010, 6'h00));
        // short response with crc check fails on crc
        events_to_send.push_back(start_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        events_to_send.push_back(status_ev(4'b1110, 6'h00));
        // long response ignores its crc fail
        events_to_send.push_back(start_ev(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        events_to_send.push_back(status_ev(4'b1100, 6'h00));
        // response first, then transfer finish closes
        events_to_send.push_back(start_ev(1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
        events_to_send.push_back(status_ev(4'b1000, 6'h00));
        events_to_send.push_back(status_ev(4'b0000, 6'h10));
        // transfer finish first, then response end closes
        events_to_send.push_back(start_ev(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        events_to_send.push_back(status_ev(4'b0000, 6'h10));
        events_to_send.push_back(status_ev(4'b1000, 6'h00));
        // data crc flag closes as success
        events_to_send.push_back(start_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        events_to_send.push_back(status_ev(4'b0000, 6'h04));
        // every data flag at once: fifo wins
        events_to_send.push_back(start_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        events_to_send.push_back(status_ev(4'b0000, 6'h3f));
        // data timeout, then a bad dma result fails the closed request again
        events_to_send.push_back(start_ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        events_to_send.push_back(status_ev(4'b0000, 6'h08));
        events_to_send.push_back(dma_ev(1'b0, 1'b0));
        // read with words left fails; write with words left does not
        events_to_send.push_back(start_ev(1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
        events_to_send.push_back(dma_ev(1'b1, 1'b1));
        events_to_send.push_back(start_ev(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        events_to_send.push_back(dma_ev(1'b1, 1'b1));
        events_to_send.push_back(status_ev(4'b0000, 6'h20));
        // data flags without data, dma without data, replacement start
        events_to_send.push_back(start_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        events_to_send.push_back(status_ev(4'b0000, 6'h3f));
        events_to_send.push_back(dma_ev(1'b0, 1'b1));
        events_to_send.push_back(start_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        events_to_send.push_back(status_ev(4'b0001, 6'h00));
        // retire, then status with nothing awaited
        events_to_send.push_back(retire_ev());
        events_to_send.push_back(status_ev(4'hf, 6'h3f));

        // random requests: start, a few events, usually a retire; some noise
        while (events_to_send.size() < 1600) begin
            if ($urandom_range(0, 9) == 0) begin
                events_to_send.push_back(noise_ev());
            end else begin
                events_to_send.push_back(start_ev(coin(), coin(), coin(), coin(), coin()));
                n_status = $urandom_range(1, 4);
                repeat (n_status) begin
                    if ($urandom_range(0, 5) == 0)
                        events_to_send.push_back(dma_ev(coin(), coin()));
                    else
                        events_to_send.push_back(status_ev(sparse_bits(), sparse_bits()));
                end
                if ($urandom_range(0, 3) != 0)
                    events_to_send.push_back(retire_ev());
            end
        end

        // drain: everything sent and every completion back
        @(posedge aclk);
        while (!(aresetn && events_to_send.size() == 0 && !s_valid
                 && completions_due.size() == 0))
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d transactions sent, %0d results checked, %0d receiver hold-offs",
                 n_accepted, n_results, holds_done);
        $display("%0d requests closed: %0d with command error, %0d with data error",
                 n_closed, n_cmd_errs, n_data_errs);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
